@@ src/tmcu_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmcu_pkg
// Shared types for the tour move cost update block: beat payloads, opcodes,
// controller states and the command/status bundles between the two halves.
// ----------------------------------------------------------------------------
package tmcu_pkg;

	typedef struct packed {
		logic [2:0]  opcode;
		logic [6:0]  first_index;
		logic [6:0]  second_index;
		logic [15:0] weight_value;
	} in_item_t;

	typedef struct packed {
		logic [21:0] tour_total;
		logic        index_error;
	} out_item_t;

	typedef enum logic [2:0] {
		OP_WR_WEIGHT = 3'd0,
		OP_IDENTITY  = 3'd1,
		OP_WR_CITY   = 3'd2,
		OP_RECOMPUTE = 3'd3,
		OP_SWAP      = 3'd4,
		OP_REVERSE   = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		RNG_ALL,
		RNG_AROUND_X,
		RNG_AROUND_Y,
		RNG_REVERSED
	} rng_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_P_CHECK,
		ST_P_RD0,
		ST_P_RD1,
		ST_P_RD2,
		ST_P_WR,
		ST_E_CHECK,
		ST_E_RD0,
		ST_E_RD1,
		ST_E_RD2,
		ST_E_WR,
		ST_RESULT
	} state_t;

	typedef struct packed {
		logic latch_in;
		logic dist_wr;
		logic city_wr;
		logic ident;
		logic rng_load;
		rng_t rng_sel;
		logic p_init;
		logic p_rd0;
		logic p_rd1;
		logic p_rd2;
		logic p_wr;
		logic e_rd0;
		logic e_rd1;
		logic e_rd2;
		logic e_wr;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic err;
		logic same;
		logic p_more;
		logic e_more;
	} sts_t;

endpackage
`default_nettype wire

@@ src/tour_move_cost_update_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tour_move_cost_update_core
// Open tour over a distance matrix with incremental cost after swap/reverse.
// ----------------------------------------------------------------------------
// Each input beat carries one opcode and returns exactly one result beat with
// the running tour total and an index error flag. One item is worked at a
// time; the input is ready again once the result is parked in the output
// register, so a new beat may enter while the last result waits. Each edge
// refresh step reads two tour entries from the single read port of the tour
// memory, reads the matrix, then updates the edge and the total. Weight/city
// writes, errors and a swap of equal positions go straight to the result;
// recompute and identity refresh every edge of the tour; a swap exchanges the
// two entries and refreshes the edges next to both positions, at most 4; a
// reverse exchanges pairs and then refreshes the edges around the span.
// The tour and edge memories have a valid bit per entry, so reset and the
// identity opcode take effect at once and no clearing pass is needed; the
// matrix must be written before it is read. The city_count register is taken
// at any time and should only change while the block is idle.
// ----------------------------------------------------------------------------
module tour_move_cost_update_core #(
	parameter int MAX_CITIES  = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_valid,
	output logic                cfg_ready,
	input  wire logic [6:0]     cfg_data,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  wire tmcu_pkg::in_item_t in_data,
	output logic                out_valid,
	input  wire logic           out_ready,
	output tmcu_pkg::out_item_t out_data
);
	import tmcu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// register writes are always taken
	assign cfg_ready = 1'b1;

	tmcu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .sts(sts)
	);

	tmcu_datapath #(.MAX_CITIES(MAX_CITIES), .WEIGHT_BITS(WEIGHT_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_data(cfg_data),
		.in_data(in_data), .cmd(cmd), .sts(sts), .out_data(out_data)
	);
endmodule
`default_nettype wire

@@ src/tmcu_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmcu_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module tmcu_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

@@ src/tmcu_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmcu_datapath
// Matrix, tour and edge stores, the running total and the index arithmetic.
// ----------------------------------------------------------------------------
module tmcu_datapath #(
	parameter int MAX_CITIES  = 64,
	parameter int WEIGHT_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_valid,
	input  wire logic [6:0]       cfg_data,
	input  wire tmcu_pkg::in_item_t in_data,
	input  wire tmcu_pkg::cmd_t   cmd,
	output tmcu_pkg::sts_t        sts,
	output tmcu_pkg::out_item_t   out_data
);
	import tmcu_pkg::*;

	localparam int AW  = $clog2(MAX_CITIES);
	localparam int QW  = $clog2(MAX_CITIES + 1) + 1;
	localparam int DD  = MAX_CITIES * MAX_CITIES;
	localparam int DAW = $clog2(DD);

	logic [6:0]             cc_q;
	op_t                    op_q;
	logic [6:0]             x_q, y_q;
	logic [WEIGHT_BITS-1:0] w_q;
	logic [21:0]            total_q;
	logic                   sub_q;
	logic [QW-1:0]          i_q, hi_q, a_q, b_q;
	logic [AW-1:0]          ca_q, da_q;
	logic [MAX_CITIES-1:0]  tour_vld_q, edge_vld_q;
	logic [AW-1:0]          traddr_q, eraddr_q;

	logic [6:0]             n_w;
	logic [QW-1:0]          nq, xq, yq, pb;
	logic [QW-1:0]          x_lo, x_hi, y_lo, y_hi, rev_hi;
	logic [6:0]             fx, fy;
	logic [31:0]            w32;
	logic                   lt_x, lt_y, err;

	logic                   t_we, t_re;
	logic [AW-1:0]          t_waddr, t_raddr, t_wdata, t_rram, tour_rd;
	logic [WEIGHT_BITS-1:0] e_rram, edge_old, dist_rd;
	logic [DAW-1:0]         d_waddr, d_raddr;

	// clamp the city count into [2, MAX_CITIES]
	always_comb begin
		if (cc_q < 7'd2) begin
			n_w = 7'd2;
		end else if (32'(cc_q) > 32'(MAX_CITIES)) begin
			n_w = 7'(MAX_CITIES);
		end else begin
			n_w = cc_q;
		end
	end

	always_comb begin
		fx = in_data.first_index;
		fy = in_data.second_index;
		if (op_t'(in_data.opcode) == OP_REVERSE && fx > fy) begin
			fx = in_data.second_index;
			fy = in_data.first_index;
		end
		w32 = 32'(in_data.weight_value);
	end

	assign lt_x = x_q < n_w;
	assign lt_y = y_q < n_w;

	always_comb begin
		case (op_q)
			OP_WR_WEIGHT, OP_WR_CITY, OP_SWAP: err = !(lt_x && lt_y);
			OP_REVERSE:                        err = y_q > n_w;
			default:                           err = 1'b0;
		endcase
	end

	assign nq = QW'(n_w);
	assign xq = QW'(x_q);
	assign yq = QW'(y_q);
	assign pb = b_q - QW'(1);

	always_comb begin
		x_lo   = (xq == '0) ? '0 : xq - QW'(1);
		y_lo   = (yq == '0) ? '0 : yq - QW'(1);
		x_hi   = ((xq + QW'(2) < nq) ? xq + QW'(2) : nq) - QW'(1);
		y_hi   = ((yq + QW'(2) < nq) ? yq + QW'(2) : nq) - QW'(1);
		rev_hi = ((yq + QW'(1) < nq) ? yq + QW'(1) : nq) - QW'(1);
	end

	assign sts.op     = op_q;
	assign sts.err    = err;
	assign sts.same   = x_q == y_q;
	assign sts.p_more = (a_q + QW'(1)) < b_q;
	assign sts.e_more = i_q < hi_q;

	// tour store: an entry never written since identity reads as its position
	always_comb begin
		t_re    = cmd.e_rd0 | cmd.e_rd1 | cmd.p_rd0 | cmd.p_rd1;
		t_raddr = AW'(a_q);
		if (cmd.e_rd0) begin
			t_raddr = AW'(i_q);
		end else if (cmd.e_rd1) begin
			t_raddr = AW'(i_q + QW'(1));
		end else if (cmd.p_rd1) begin
			t_raddr = AW'(pb);
		end
		t_we    = cmd.city_wr | cmd.p_rd2 | cmd.p_wr;
		t_waddr = AW'(x_q);
		t_wdata = AW'(y_q);
		if (cmd.p_rd2) begin
			t_waddr = AW'(a_q);
			t_wdata = tour_rd;
		end else if (cmd.p_wr) begin
			t_waddr = AW'(pb);
			t_wdata = da_q;
		end
	end

	assign tour_rd  = tour_vld_q[traddr_q] ? t_rram : traddr_q;
	assign edge_old = edge_vld_q[eraddr_q] ? e_rram : '0;
	assign d_waddr  = DAW'(AW'(x_q)) * DAW'(MAX_CITIES) + DAW'(AW'(y_q));
	assign d_raddr  = DAW'(ca_q) * DAW'(MAX_CITIES) + DAW'(tour_rd);

	tmcu_ram #(.WIDTH(AW), .DEPTH(MAX_CITIES)) u_tour (
		.clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
		.re(t_re), .raddr(t_raddr), .rdata(t_rram)
	);

	tmcu_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_CITIES)) u_edge (
		.clk(clk), .we(cmd.e_wr), .waddr(AW'(i_q)), .wdata(dist_rd),
		.re(cmd.e_rd0), .raddr(AW'(i_q)), .rdata(e_rram)
	);

	tmcu_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(DD)) u_dist (
		.clk(clk), .we(cmd.dist_wr), .waddr(d_waddr), .wdata(w_q),
		.re(cmd.e_rd2), .raddr(d_raddr), .rdata(dist_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cc_q       <= 7'd64;
			total_q    <= '0;
			tour_vld_q <= '0;
			edge_vld_q <= '0;
		end else begin
			if (cfg_valid) begin
				cc_q <= cfg_data;
			end
			if (cmd.ident) begin
				tour_vld_q <= '0;
			end else if (t_we) begin
				tour_vld_q[t_waddr] <= 1'b1;
			end
			if (cmd.e_wr) begin
				edge_vld_q[AW'(i_q)] <= 1'b1;
				total_q <= total_q - (sub_q ? 22'(edge_old) : 22'd0) + 22'(dist_rd);
			end else if (cmd.rng_load && cmd.rng_sel == RNG_ALL) begin
				total_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q <= op_t'(in_data.opcode);
			x_q  <= fx;
			y_q  <= fy;
			w_q  <= w32[WEIGHT_BITS-1:0];
		end
		if (t_re) begin
			traddr_q <= t_raddr;
		end
		if (cmd.e_rd0) begin
			eraddr_q <= AW'(i_q);
		end
		if (cmd.e_rd1) begin
			ca_q <= tour_rd;
		end
		if (cmd.p_rd1) begin
			da_q <= tour_rd;
		end
		if (cmd.p_init) begin
			a_q <= xq;
			b_q <= (op_q == OP_SWAP) ? yq + QW'(1) : yq;
		end else if (cmd.p_wr) begin
			a_q <= a_q + QW'(1);
			b_q <= pb;
		end
		if (cmd.rng_load) begin
			case (cmd.rng_sel)
				RNG_ALL: begin
					i_q   <= '0;
					hi_q  <= nq - QW'(1);
					sub_q <= 1'b0;
				end
				RNG_AROUND_X: begin
					i_q   <= x_lo;
					hi_q  <= x_hi;
					sub_q <= 1'b1;
				end
				RNG_AROUND_Y: begin
					i_q   <= y_lo;
					hi_q  <= y_hi;
					sub_q <= 1'b1;
				end
				default: begin
					i_q   <= x_lo;
					hi_q  <= rev_hi;
					sub_q <= 1'b1;
				end
			endcase
		end else if (cmd.e_wr) begin
			i_q <= i_q + QW'(1);
		end
		if (cmd.out_load) begin
			out_data.tour_total  <= total_q;
			out_data.index_error <= err;
		end
	end
endmodule
`default_nettype wire

@@ src/tmcu_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tmcu_ctrl
// Sequencer for one item: pair exchanges, edge refresh loop, result beat.
// ----------------------------------------------------------------------------
module tmcu_ctrl (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	output tmcu_pkg::cmd_t cmd,
	input  wire tmcu_pkg::sts_t sts
);
	import tmcu_pkg::*;

	state_t st_q, st_n;
	logic   y_pend_q, y_pend_n;
	logic   out_valid_q;

	assign in_ready  = st_q == ST_IDLE;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			y_pend_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q     <= st_n;
			y_pend_q <= y_pend_n;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		cmd      = '0;
		st_n     = st_q;
		y_pend_n = y_pend_q;
		case (st_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					st_n = ST_DECODE;
				end
			end
			ST_DECODE: begin
				st_n = ST_RESULT;
				if (!sts.err) begin
					case (sts.op)
						OP_WR_WEIGHT: cmd.dist_wr = 1'b1;
						OP_WR_CITY:   cmd.city_wr = 1'b1;
						OP_IDENTITY: begin
							cmd.ident    = 1'b1;
							cmd.rng_load = 1'b1;
							cmd.rng_sel  = RNG_ALL;
							st_n = ST_E_CHECK;
						end
						OP_RECOMPUTE: begin
							cmd.rng_load = 1'b1;
							cmd.rng_sel  = RNG_ALL;
							st_n = ST_E_CHECK;
						end
						OP_SWAP: begin
							if (!sts.same) begin
								cmd.p_init = 1'b1;
								st_n = ST_P_RD0;
							end
						end
						OP_REVERSE: begin
							cmd.p_init = 1'b1;
							st_n = ST_P_CHECK;
						end
						default: st_n = ST_RESULT;
					endcase
				end
			end
			ST_P_CHECK: begin
				if (sts.p_more) begin
					st_n = ST_P_RD0;
				end else begin
					cmd.rng_load = 1'b1;
					cmd.rng_sel  = RNG_REVERSED;
					st_n = ST_E_CHECK;
				end
			end
			ST_P_RD0: begin
				cmd.p_rd0 = 1'b1;
				st_n = ST_P_RD1;
			end
			ST_P_RD1: begin
				cmd.p_rd1 = 1'b1;
				st_n = ST_P_RD2;
			end
			ST_P_RD2: begin
				cmd.p_rd2 = 1'b1;
				st_n = ST_P_WR;
			end
			ST_P_WR: begin
				cmd.p_wr = 1'b1;
				if (sts.op == OP_SWAP) begin
					cmd.rng_load = 1'b1;
					cmd.rng_sel  = RNG_AROUND_X;
					y_pend_n = 1'b1;
					st_n = ST_E_CHECK;
				end else begin
					st_n = ST_P_CHECK;
				end
			end
			ST_E_CHECK: begin
				if (sts.e_more) begin
					st_n = ST_E_RD0;
				end else if (y_pend_q) begin
					cmd.rng_load = 1'b1;
					cmd.rng_sel  = RNG_AROUND_Y;
					y_pend_n = 1'b0;
				end else begin
					st_n = ST_RESULT;
				end
			end
			ST_E_RD0: begin
				cmd.e_rd0 = 1'b1;
				st_n = ST_E_RD1;
			end
			ST_E_RD1: begin
				cmd.e_rd1 = 1'b1;
				st_n = ST_E_RD2;
			end
			ST_E_RD2: begin
				cmd.e_rd2 = 1'b1;
				st_n = ST_E_WR;
			end
			ST_E_WR: begin
				cmd.e_wr = 1'b1;
				st_n = ST_E_CHECK;
			end
			ST_RESULT: begin
				if (!out_valid_q || out_ready) begin
					cmd.out_load = 1'b1;
					st_n = ST_IDLE;
				end
			end
			default: st_n = ST_IDLE;
		endcase
	end

	a_accept_decode: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> st_q == ST_DECODE)
		else $error("accepted beat not decoded");

	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> out_valid_q && in_ready)
		else $error("result beat not presented");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.e_rd0, cmd.e_rd1, cmd.e_rd2, cmd.e_wr,
			cmd.p_rd0, cmd.p_rd1, cmd.p_rd2, cmd.p_wr, cmd.out_load}))
		else $error("datapath steps overlap");

	a_y_pend_swap: assert property (@(posedge clk) disable iff (!arst_n)
		y_pend_q |-> sts.op == OP_SWAP)
		else $error("second refresh pending outside a swap");
endmodule
`default_nettype wire

@@ tb/tour_cost_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tour_cost_checker
// Watches the config, input and result channels of the tour cost block. Keeps
// its own copy of the matrix, tour, edge weights and total, predicts one result
// per accepted input beat and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module tour_cost_checker (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic                cfg_ready,
	input  wire logic [6:0]          cfg_data,
	input  wire logic                in_valid,
	input  wire logic                in_ready,
	input  tmcu_pkg::in_item_t       in_data,
	input  wire logic                out_valid,
	input  wire logic                out_ready,
	input  tmcu_pkg::out_item_t      out_data,
	output int                       fail_count,
	output int                       outstanding,
	output int                       results_seen,
	output int                       flagged_seen
);
	import tmcu_pkg::*;

	localparam int CITIES = 64;

	logic [15:0] dist_mem [CITIES][CITIES];
	logic [5:0]  tour_city [CITIES];
	logic [15:0] edge_w [CITIES];
	logic [21:0] cost;
	logic [6:0]  count_reg;
	out_item_t   pending_q [$];

	function automatic int cities_in_use();
		if (count_reg < 7'd2) return 2;
		if (count_reg > CITIES) return CITIES;
		return int'(count_reg);
	endfunction

	task automatic refresh_edge(input int i);
		if (i + 1 >= CITIES) return;
		cost = cost - 22'(edge_w[i]);
		edge_w[i] = dist_mem[tour_city[i]][tour_city[i + 1]];
		cost = cost + 22'(edge_w[i]);
	endtask

	task automatic rescan_tour(input int n);
		cost = '0;
		for (int i = 0; i + 1 < n; i++) begin
			edge_w[i] = dist_mem[tour_city[i]][tour_city[i + 1]];
			cost = cost + 22'(edge_w[i]);
		end
	endtask

	task automatic refresh_near(input int p, input int n);
		int lo;
		int top;
		lo = (p > 0) ? p - 1 : 0;
		top = (p + 2 < n) ? p + 2 : n;
		for (int i = lo; i <= top - 2; i++) refresh_edge(i);
	endtask

	task automatic predict_cost(input in_item_t b, output out_item_t r);
		int n;
		int x;
		int y;
		int a;
		int z;
		int lo;
		int hi;
		logic err;
		logic [5:0] t;
		n = cities_in_use();
		x = int'(b.first_index);
		y = int'(b.second_index);
		err = 1'b0;
		case (b.opcode)
			OP_WR_WEIGHT: begin
				if (x < n && y < n) dist_mem[x][y] = b.weight_value;
				else err = 1'b1;
			end
			OP_IDENTITY: begin
				for (int i = 0; i < CITIES; i++) tour_city[i] = 6'(i);
				rescan_tour(n);
			end
			OP_WR_CITY: begin
				if (x < n && y < n) tour_city[x] = 6'(y);
				else err = 1'b1;
			end
			OP_RECOMPUTE: rescan_tour(n);
			OP_SWAP: begin
				if (x >= n || y >= n) err = 1'b1;
				else if (x != y) begin
					t = tour_city[x];
					tour_city[x] = tour_city[y];
					tour_city[y] = t;
					refresh_near(x, n);
					refresh_near(y, n);
				end
			end
			OP_REVERSE: begin
				if (x > y) begin
					a = x;
					x = y;
					y = a;
				end
				if (y > n) err = 1'b1;
				else begin
					a = x;
					z = y;
					while (a + 1 < z) begin
						t = tour_city[a];
						tour_city[a] = tour_city[z - 1];
						tour_city[z - 1] = t;
						a++;
						z--;
					end
					lo = (x > 0) ? x - 1 : 0;
					hi = ((y + 1 < n) ? y + 1 : n) - 1;
					for (int i = lo; i < hi; i++) refresh_edge(i);
				end
			end
			default: ;
		endcase
		r.tour_total = cost;
		r.index_error = err;
	endtask

	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		out_item_t got;
		if (!arst_n) begin
			for (int i = 0; i < CITIES; i++) begin
				tour_city[i] = 6'(i);
				edge_w[i] = '0;
			end
			cost = '0;
			count_reg = 7'd64;
			pending_q.delete();
			fail_count = 0;
			outstanding = 0;
			results_seen = 0;
			flagged_seen = 0;
		end else begin
			if (cfg_valid && cfg_ready) count_reg = cfg_data;
			if (out_valid && out_ready) begin
				got = out_data;
				results_seen++;
				if (got.index_error) flagged_seen++;
				if (pending_q.size() == 0) begin
					fail_count++;
					$display("%0t: result beat with nothing expected: total %0d err %0b",
						$time, got.tour_total, got.index_error);
				end else begin
					want = pending_q.pop_front();
					if (got.tour_total !== want.tour_total) begin
						fail_count++;
						$display("%0t: tour_total expected %0d actual %0d",
							$time, want.tour_total, got.tour_total);
					end
					if (got.index_error !== want.index_error) begin
						fail_count++;
						$display("%0t: index_error expected %0b actual %0b",
							$time, want.index_error, got.index_error);
					end
				end
			end
			if (in_valid && in_ready) begin
				predict_cost(in_data, want);
				pending_q.push_back(want);
			end
			outstanding = pending_q.size();
		end
	end

endmodule

@@ tb/tour_move_cost_update_core_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tour_move_cost_update_core_tb
// Drives the tour cost block through several city counts: matrix fills, tour
// moves, recomputes, bad indices and spare opcodes, with random gaps on both
// sides. The checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tour_move_cost_update_core_tb;
	import tmcu_pkg::*;

	// spare opcodes the block must ignore without a flag
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [6:0]  cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	in_item_t    in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	out_item_t   out_data;
	logic        gaps_on = 1'b1;
	int          fail_count;
	int          outstanding;
	int          results_seen;
	int          flagged_seen;
	int          beats_sent = 0;

	always #6 clk = ~clk;

	tour_move_cost_update_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	tour_cost_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.outstanding  (outstanding),
		.results_seen (results_seen),
		.flagged_seen (flagged_seen)
	);

	// Stall the result side with a chance of 18 in a hundred while gaps are on.
	always @(posedge clk) begin
		out_ready <= gaps_on ? ($urandom_range(99) >= 18) : 1'b1;
	end

	// Hard stop well beyond the slowest legal run.
	initial begin
		#30_000_000;
		$display("TEST FAILED");
		$finish;
	end

	// Send one input beat: maybe idle first, then hold valid until accepted.
	task automatic push_beat(input logic [2:0] op, input int x, input int y,
			input logic [15:0] w);
		logic rdy;
		if (gaps_on) begin
			while ($urandom_range(99) < 18) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid <= 1'b1;
		in_data.opcode <= op;
		in_data.first_index <= 7'(x);
		in_data.second_index <= 7'(y);
		in_data.weight_value <= w;
		do begin
			@(negedge clk);
			rdy = in_ready;
			@(posedge clk);
		end while (!rdy);
		beats_sent++;
	endtask

	// Drop valid and hold off until every expected result has come back.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		@(posedge clk);
	endtask

	// Write the city count while the block is idle.
	task automatic set_cities(input int n);
		logic rdy;
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= 7'(n);
		do begin
			@(negedge clk);
			rdy = cfg_ready;
			@(posedge clk);
		end while (!rdy);
		cfg_valid <= 1'b0;
	endtask

	// Fill the whole n x n corner of the matrix with random weights.
	task automatic fill_matrix(input int n);
		for (int r = 0; r < n; r++)
			for (int c = 0; c < n; c++)
				push_beat(OP_WR_WEIGHT, r, c, 16'($urandom_range(65535)));
	endtask

	// Random mix over an n-city tour whose cities all have written matrix rows.
	task automatic random_moves(input int count, input int n);
		int k;
		int x;
		int y;
		logic [2:0] op;
		for (int j = 0; j < count; j++) begin
			k = $urandom_range(99);
			x = $urandom_range(n - 1);
			y = $urandom_range(n - 1);
			if (k < 22) push_beat(OP_WR_WEIGHT, x, y, 16'($urandom_range(65535)));
			else if (k < 32) push_beat(OP_WR_CITY, x, y, 16'($urandom));
			else if (k < 37) push_beat(OP_RECOMPUTE, x, y, 16'($urandom));
			else if (k < 62) push_beat(OP_SWAP, x, y, 16'($urandom));
			else if (k < 87) push_beat(OP_REVERSE, $urandom_range(n), $urandom_range(n),
				16'($urandom));
			else if (k < 90) push_beat(OP_IDENTITY, x, y, 16'($urandom));
			else if (k < 96) begin
				// bad index on one side, any operation that checks indices
				case ($urandom_range(3))
					0: op = OP_WR_WEIGHT;
					1: op = OP_WR_CITY;
					2: op = OP_SWAP;
					default: op = OP_REVERSE;
				endcase
				x = (op == OP_REVERSE) ? $urandom_range(127, n + 1) : $urandom_range(127, n);
				if ($urandom_range(1)) push_beat(op, x, y, 16'($urandom));
				else push_beat(op, y, x, 16'($urandom));
			end else begin
				op = $urandom_range(1) ? OP_SPARE_HI : OP_SPARE_LO;
				push_beat(op, $urandom_range(127), $urandom_range(127), 16'($urandom));
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full 64-city tour at reset count: write only the forward and
		// backward neighbour weights, then moves that stay on them.
		for (int i = 0; i < 63; i++) begin
			push_beat(OP_WR_WEIGHT, i, i + 1, 16'hFFFF);
			push_beat(OP_WR_WEIGHT, i + 1, i, 16'($urandom_range(65535)));
		end
		push_beat(OP_IDENTITY, 0, 0, 16'h0000);
		push_beat(OP_RECOMPUTE, 0, 0, 16'h0000);
		push_beat(OP_REVERSE, 0, 64, 16'h0000);
		push_beat(OP_REVERSE, 64, 0, 16'h0000);
		push_beat(OP_REVERSE, 7, 7, 16'h0000);
		push_beat(OP_REVERSE, 7, 8, 16'h0000);
		push_beat(OP_REVERSE, 0, 1, 16'h0000);
		push_beat(OP_REVERSE, 63, 64, 16'h0000);
		push_beat(OP_SWAP, 5, 5, 16'h0000);
		push_beat(OP_WR_CITY, 3, 3, 16'h0000);
		push_beat(OP_WR_WEIGHT, 64, 0, 16'hFFFF);
		push_beat(OP_WR_WEIGHT, 0, 127, 16'hFFFF);
		push_beat(OP_WR_CITY, 127, 0, 16'h0000);
		push_beat(OP_WR_CITY, 0, 64, 16'h0000);
		push_beat(OP_SWAP, 0, 64, 16'h0000);
		push_beat(OP_REVERSE, 0, 65, 16'h0000);
		push_beat(OP_REVERSE, 127, 127, 16'hFFFF);
		push_beat(OP_SPARE_LO, 127, 127, 16'hFFFF);
		push_beat(OP_SPARE_HI, 0, 0, 16'h0000);

		// Sixteen cities: fill the matrix corner, then random moves. Run the
		// first stretch with no gaps at all.
		set_cities(16);
		gaps_on <= 1'b0;
		fill_matrix(16);
		push_beat(OP_IDENTITY, 0, 0, 16'h0000);
		random_moves(150, 16);
		gaps_on <= 1'b1;
		random_moves(330, 16);

		// Shrink without a restart of the tour; cities up to 15 remain.
		set_cities(8);
		push_beat(OP_RECOMPUTE, 0, 0, 16'h0000);
		random_moves(300, 8);

		// Grow again with stale edges past the short tour; totals may wrap.
		set_cities(16);
		random_moves(300, 16);

		// Smallest counts, including a value below the floor.
		set_cities(2);
		random_moves(80, 2);
		set_cities(0);
		random_moves(40, 2);

		// Counts above the ceiling act as 64 cities.
		set_cities(127);
		push_beat(OP_IDENTITY, 0, 0, 16'h0000);
		push_beat(OP_REVERSE, 0, 64, 16'h0000);
		push_beat(OP_REVERSE, 0, 127, 16'h0000);
		push_beat(OP_SWAP, 64, 3, 16'h0000);
		set_cities(64);
		push_beat(OP_IDENTITY, 0, 0, 16'h0000);
		push_beat(OP_REVERSE, 64, 0, 16'h0000);
		push_beat(OP_RECOMPUTE, 0, 0, 16'h0000);

		drain_results();
		repeat (20) @(posedge clk);
		$display("Covered city counts 64, 16, 8, 2, 0 and 127 across %0d input beats.",
			beats_sent);
		$display("Checked %0d result beats, %0d of them with the index error flag.",
			results_seen, flagged_seen);
		if (fail_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
